// ===== design/tgapsd_pkg.sv =====
// ----------------------------------------------------------------------------
// tgapsd_pkg
// Shared constants for the truecolor pixel stream decoder: count widths,
// image mode codes and configuration register indexes.
// ----------------------------------------------------------------------------
package tgapsd_pkg;

  localparam int unsigned PixelCountBits = 24;
  localparam int unsigned CfgIndexBits   = 2;
  localparam int unsigned CfgDataBits    = 24;

  typedef logic [PixelCountBits-1:0] pix_cnt_t;
  typedef logic [CfgIndexBits-1:0]   cfg_index_t;
  typedef logic [CfgDataBits-1:0]    cfg_data_t;

  localparam logic [1:0] ModeNone = 2'd0;
  localparam logic [1:0] ModeRaw  = 2'd1;
  localparam logic [1:0] ModeRle  = 2'd2;

  localparam cfg_index_t CfgImageMode  = 2'd0;
  localparam cfg_index_t CfgHasAlpha   = 2'd1;
  localparam cfg_index_t CfgPixelTotal = 2'd2;

endpackage

// ===== design/tga_pixel_stream_decoder_core.sv =====
// ----------------------------------------------------------------------------
// tga_pixel_stream_decoder_core
// Decodes the pixel-data bytes of a raw or run-length truecolor image into
// pixels with swapped first and third bytes and a repeat count.
//
//   Channel | Handshake                    | Payload
//   --------+------------------------------+----------------------------------
//   in      | in_valid_i / in_ready_o      | data_byte_i
//   out     | out_valid_o / out_ready_i    | chan0..3_o, repeat_count_o,
//           |                              | image_done_o, run_clamped_o
//   cfg     | cfg_valid_i / cfg_ready_o    | cfg_index_i, cfg_data_i
//
// One byte per cycle unless a stalled result holds the byte register; a pixel
// result is registered from the byte register that holds its last byte.
// The byte register feeds one pass of counter and packet logic into the
// result register; a byte that yields no result never waits on out_ready_i.
// Reset clears all control state; no clearing pass is needed.
// A stalled result holds the byte register only when that byte also emits.
// ----------------------------------------------------------------------------
module tga_pixel_stream_decoder_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [7:0]             data_byte_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [7:0]             chan0_o,
  output logic [7:0]             chan1_o,
  output logic [7:0]             chan2_o,
  output logic [7:0]             chan3_o,
  output logic [7:0]             repeat_count_o,
  output logic                   image_done_o,
  output logic                   run_clamped_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  tgapsd_pkg::cfg_index_t cfg_index_i,
  input  tgapsd_pkg::cfg_data_t  cfg_data_i
);
  import tgapsd_pkg::*;

  logic [1:0] image_mode_q;
  logic       has_alpha_q;
  pix_cnt_t   pixel_total_q;

  pix_cnt_t    pixels_left_q, pixels_left_d;
  logic [1:0]  byte_phase_q, byte_phase_d;
  logic        expect_q, expect_d;
  logic        is_run_q, is_run_d;
  logic [6:0]  packet_left_q, packet_left_d;
  logic [23:0] gathered_q, gathered_d;

  logic       in_valid_q;
  logic [7:0] byte_q;

  logic        out_valid_q;
  logic [7:0]  chan0_q, chan1_q, chan2_q, chan3_q, rep_q;
  logic        done_q, clamped_q;

  logic        cfg_wr;
  logic        start, mode_ok, emit, proc;
  pix_cnt_t    eff_pl, new_pl;
  logic [1:0]  eff_phase, last_phase;
  logic        eff_expect, eff_run;
  logic [6:0]  eff_pleft;
  logic [7:0]  cnt, rep;
  logic        clamped;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i;

  always_comb begin
    mode_ok    = (image_mode_q == ModeRaw) || (image_mode_q == ModeRle);
    start      = (pixels_left_q == '0);
    eff_pl     = start ? pixel_total_q : pixels_left_q;
    eff_phase  = start ? 2'd0 : byte_phase_q;
    eff_expect = start ? 1'b1 : expect_q;
    eff_run    = start ? 1'b0 : is_run_q;
    eff_pleft  = start ? 7'd0 : packet_left_q;
    last_phase = has_alpha_q ? 2'd3 : 2'd2;
    cnt        = {1'b0, eff_pleft} + 8'd1;

    pixels_left_d = pixels_left_q;
    byte_phase_d  = byte_phase_q;
    expect_d      = expect_q;
    is_run_d      = is_run_q;
    packet_left_d = packet_left_q;
    gathered_d    = gathered_q;
    emit          = 1'b0;
    rep           = 8'd1;
    clamped       = 1'b0;
    new_pl        = eff_pl;

    if (mode_ok && eff_pl != '0) begin
      pixels_left_d = eff_pl;
      byte_phase_d  = eff_phase;
      expect_d      = eff_expect;
      is_run_d      = eff_run;
      packet_left_d = eff_pleft;
      if (image_mode_q == ModeRle && eff_expect) begin
        is_run_d      = byte_q[7];
        packet_left_d = byte_q[6:0];
        expect_d      = 1'b0;
      end else begin
        case (eff_phase)
          2'd0:    gathered_d[7:0]   = byte_q;
          2'd1:    gathered_d[15:8]  = byte_q;
          2'd2:    gathered_d[23:16] = byte_q;
          default: gathered_d        = gathered_q;
        endcase
        if (eff_phase < last_phase) begin
          byte_phase_d = eff_phase + 2'd1;
        end else begin
          emit         = 1'b1;
          byte_phase_d = 2'd0;
          if (image_mode_q == ModeRle) begin
            if (eff_run) begin
              if (pix_cnt_t'(cnt) > eff_pl) begin
                rep     = eff_pl[7:0];
                clamped = 1'b1;
              end else begin
                rep = cnt;
              end
              packet_left_d = 7'd0;
              expect_d      = 1'b1;
            end else if (eff_pleft == 7'd0) begin
              expect_d = 1'b1;
            end else begin
              packet_left_d = eff_pleft - 7'd1;
              clamped       = (eff_pl == pix_cnt_t'(1));
            end
          end
          new_pl        = eff_pl - pix_cnt_t'(rep);
          pixels_left_d = new_pl;
          if (new_pl == '0) begin
            byte_phase_d  = 2'd0;
            expect_d      = 1'b1;
            is_run_d      = 1'b0;
            packet_left_d = 7'd0;
          end
        end
      end
    end
  end

  assign proc       = in_valid_q && (!emit || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= data_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_mode_q  <= ModeNone;
      has_alpha_q   <= 1'b0;
      pixel_total_q <= '0;
      pixels_left_q <= '0;
      byte_phase_q  <= 2'd0;
      expect_q      <= 1'b1;
      is_run_q      <= 1'b0;
      packet_left_q <= 7'd0;
      gathered_q    <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_index_i)
        CfgImageMode:  image_mode_q  <= cfg_data_i[1:0];
        CfgHasAlpha:   has_alpha_q   <= cfg_data_i[0];
        CfgPixelTotal: pixel_total_q <= pix_cnt_t'(cfg_data_i);
        default:       image_mode_q  <= image_mode_q;
      endcase
      pixels_left_q <= '0;
      byte_phase_q  <= 2'd0;
      expect_q      <= 1'b1;
      is_run_q      <= 1'b0;
      packet_left_q <= 7'd0;
    end else if (proc) begin
      pixels_left_q <= pixels_left_d;
      byte_phase_q  <= byte_phase_d;
      expect_q      <= expect_d;
      is_run_q      <= is_run_d;
      packet_left_q <= packet_left_d;
      gathered_q    <= gathered_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && emit) begin
      chan0_q   <= gathered_d[23:16];
      chan1_q   <= gathered_d[15:8];
      chan2_q   <= gathered_d[7:0];
      chan3_q   <= has_alpha_q ? byte_q : 8'd0;
      rep_q     <= rep;
      done_q    <= (new_pl == '0);
      clamped_q <= clamped;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign chan0_o        = chan0_q;
  assign chan1_o        = chan1_q;
  assign chan2_o        = chan2_q;
  assign chan3_o        = chan3_q;
  assign repeat_count_o = rep_q;
  assign image_done_o   = done_q;
  assign run_clamped_o  = clamped_q;

  a_idle_rearmed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pixels_left_q == '0 |-> byte_phase_q == 2'd0 && expect_q && !is_run_q
                            && packet_left_q == 7'd0)
    else $error("decoder idle with packet or byte state left over");

  a_rep_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> rep_q != 8'd0 && rep_q <= 8'd128)
    else $error("repeat count out of range");

  a_clamp_ends_image: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && clamped_q |-> done_q)
    else $error("clamped result does not end the image");

  a_phase_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_phase_q == 2'd3 |-> has_alpha_q)
    else $error("fourth byte phase without alpha");

endmodule

// ===== verif/tga_pixel_stream_decoder_core_tb.sv =====
// ----------------------------------------------------------------------------
// tga_pixel_stream_decoder_core_tb
// Streams raw and run-length image bytes into the decoder under random
// idling and output stalls. A byte-level predictor tracks the decoder state
// and queues the expected pixels. Each pixel leaving the block is checked
// field by field against the oldest queued pixel.
// ----------------------------------------------------------------------------
module tga_pixel_stream_decoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tgapsd_pkg::*;

  localparam logic [1:0] ModeUnknown = 2'd3;
  localparam cfg_index_t CfgUnmapped = 2'd3;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned RandomBytes = 1000;

  typedef struct packed {
    logic [7:0] chan0;
    logic [7:0] chan1;
    logic [7:0] chan2;
    logic [7:0] chan3;
    logic [7:0] repeat_count;
    logic       image_done;
    logic       run_clamped;
  } pixel_out_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] data_byte_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] chan0_o;
  logic [7:0] chan1_o;
  logic [7:0] chan2_o;
  logic [7:0] chan3_o;
  logic [7:0] repeat_count_o;
  logic       image_done_o;
  logic       run_clamped_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  cfg_index_t cfg_index_i = '0;
  cfg_data_t  cfg_data_i = '0;

  tga_pixel_stream_decoder_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .chan0_o        (chan0_o),
    .chan1_o        (chan1_o),
    .chan2_o        (chan2_o),
    .chan3_o        (chan3_o),
    .repeat_count_o (repeat_count_o),
    .image_done_o   (image_done_o),
    .run_clamped_o  (run_clamped_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // Decoder shadow: configuration and state.
  logic [1:0]  cfg_mode = ModeNone;
  logic        cfg_alpha = 1'b0;
  pix_cnt_t    cfg_total = '0;
  pix_cnt_t    pix_left = '0;
  logic [1:0]  byte_ph = '0;
  logic        want_packet = 1'b1;
  logic        run_pkt = 1'b0;
  logic [6:0]  pkt_left = '0;
  logic [23:0] gathered = '0;

  logic [7:0]  byte_backlog[$];
  logic [7:0]  image_bytes[$];
  pixel_out_t  awaited_pixels[$];
  int          mismatch_count = 0;
  int          idle_cycles = 0;
  int          in_gap = 0;
  int          out_hold = 0;
  bit          quiet = 1'b0;

  function automatic int draw_gap();
    return quiet ? 0 : $urandom_range(0, 14);
  endfunction

  function automatic void rearm_decoder();
    pix_left = '0;
    byte_ph = '0;
    want_packet = 1'b1;
    run_pkt = 1'b0;
    pkt_left = '0;
  endfunction

  function automatic void decode_byte(input logic [7:0] b);
    logic [1:0] last_ph;
    logic [7:0] rep;
    logic [7:0] run_len;
    logic       clamp;
    pixel_out_t px;
    if (cfg_mode != ModeRaw && cfg_mode != ModeRle) return;
    if (pix_left == '0) begin
      if (cfg_total == '0) return;
      rearm_decoder();
      pix_left = cfg_total;
    end
    if (cfg_mode == ModeRle && want_packet) begin
      run_pkt = b[7];
      pkt_left = b[6:0];
      want_packet = 1'b0;
      return;
    end
    last_ph = cfg_alpha ? 2'd3 : 2'd2;
    case (byte_ph)
      2'd0: gathered[7:0] = b;
      2'd1: gathered[15:8] = b;
      2'd2: gathered[23:16] = b;
      default: ;
    endcase
    if (byte_ph < last_ph) begin
      byte_ph = byte_ph + 2'd1;
      return;
    end
    byte_ph = '0;
    rep = 8'd1;
    clamp = 1'b0;
    if (cfg_mode == ModeRle) begin
      if (run_pkt) begin
        run_len = {1'b0, pkt_left} + 8'd1;
        if (pix_cnt_t'(run_len) > pix_left) begin
          rep = pix_left[7:0];
          clamp = 1'b1;
        end else begin
          rep = run_len;
        end
        pkt_left = '0;
        want_packet = 1'b1;
      end else if (pkt_left == '0) begin
        want_packet = 1'b1;
      end else begin
        pkt_left = pkt_left - 7'd1;
        if (pix_left == pix_cnt_t'(1)) clamp = 1'b1;
      end
    end
    pix_left = pix_left - pix_cnt_t'(rep);
    px.chan0 = gathered[23:16];
    px.chan1 = gathered[15:8];
    px.chan2 = gathered[7:0];
    px.chan3 = cfg_alpha ? b : 8'd0;
    px.repeat_count = rep;
    px.image_done = (pix_left == '0);
    px.run_clamped = clamp;
    awaited_pixels.push_back(px);
    if (pix_left == '0) rearm_decoder();
  endfunction

  task automatic check_field(input string label, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t %s: expected %0h, got %0h", $time, label, want, got);
      mismatch_count++;
    end
  endtask

  task automatic check_pixel();
    pixel_out_t px;
    if (awaited_pixels.size() == 0) begin
      $display("%0t unexpected pixel: expected none, got %0h %0h %0h %0h rep %0d", $time,
               chan0_o, chan1_o, chan2_o, chan3_o, repeat_count_o);
      mismatch_count++;
    end else begin
      px = awaited_pixels.pop_front();
      check_field("chan0", px.chan0, chan0_o);
      check_field("chan1", px.chan1, chan1_o);
      check_field("chan2", px.chan2, chan2_o);
      check_field("chan3", px.chan3, chan3_o);
      check_field("repeat_count", px.repeat_count, repeat_count_o);
      check_field("image_done", 8'(px.image_done), 8'(image_done_o));
      check_field("run_clamped", 8'(px.run_clamped), 8'(run_clamped_o));
    end
  endtask

  // Byte driver: predict on every accepted transaction, then hold off or advance.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        decode_byte(data_byte_i);
        in_gap = draw_gap();
      end
      if (!in_valid_i || in_ready_o) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (byte_backlog.size() > 0) begin
          data_byte_i <= byte_backlog.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Pixel monitor with random backpressure.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        check_pixel();
        out_hold = draw_gap();
      end else if (out_hold > 0) begin
        out_hold--;
      end
      out_ready_i <= (out_hold == 0);
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_cycles = 0;
    end else if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
                 (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("%0t watchdog: no transaction for %0d cycles", $time, idle_cycles);
        $display("tga_pixel_stream_decoder_core_tb: done, errors");
        $finish;
      end
    end
  end

  task automatic wait_quiet();
    do @(negedge clk_i);
    while (byte_backlog.size() != 0 || in_valid_i || awaited_pixels.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_index_t idx, input cfg_data_t val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    case (idx)
      CfgImageMode: cfg_mode = val[1:0];
      CfgHasAlpha: cfg_alpha = val[0];
      CfgPixelTotal: cfg_total = val;
      default: ;
    endcase
    rearm_decoder();
  endtask

  task automatic load_image(input logic [1:0] mode, input logic alpha, input pix_cnt_t total);
    cfg_data_t noise;
    wait_quiet();
    noise = cfg_data_t'($urandom);
    if ($urandom_range(0, 5) == 0) write_reg(CfgUnmapped, noise);
    write_reg(CfgImageMode, {noise[23:2], mode});
    noise = cfg_data_t'($urandom);
    write_reg(CfgHasAlpha, {noise[23:1], alpha});
    write_reg(CfgPixelTotal, total);
    cfg_valid_i <= 1'b0;
    quiet = ($urandom_range(0, 3) == 0);
  endtask

  task automatic add_pixel(input logic alpha);
    repeat (alpha ? 4 : 3) image_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic build_image(input logic [1:0] mode, input logic alpha, input pix_cnt_t total);
    pix_cnt_t   left;
    int         shown;
    logic       run;
    logic [6:0] cnt;
    left = total;
    shown = 0;
    while (left != '0 && shown < 48) begin
      if (mode == ModeRle) begin
        run = 1'($urandom_range(0, 1));
        cnt = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127)) :
                                            7'($urandom_range(0, 6));
        image_bytes.push_back({run, cnt});
        if (run) begin
          add_pixel(alpha);
          shown++;
          if (pix_cnt_t'(cnt) + pix_cnt_t'(1) > left) left = '0;
          else left = left - pix_cnt_t'(cnt) - pix_cnt_t'(1);
        end else begin
          repeat (int'(cnt) + 1) begin
            if (left != '0) begin
              add_pixel(alpha);
              shown++;
              left = left - pix_cnt_t'(1);
            end
          end
        end
      end else begin
        add_pixel(alpha);
        shown++;
        left = left - pix_cnt_t'(1);
      end
    end
  endtask

  task automatic push_list(input logic [7:0] list[$]);
    foreach (list[i]) byte_backlog.push_back(list[i]);
  endtask

  initial begin
    logic [1:0] mode;
    logic       alpha;
    pix_cnt_t   total;
    int         sent;
    int         pick;
    int         keep;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_list('{8'h5A, 8'hC3});
    load_image(ModeRaw, 1'b0, pix_cnt_t'(1));
    push_list('{8'h00, 8'hFF, 8'hA5});
    load_image(ModeRaw, 1'b1, pix_cnt_t'(1));
    push_list('{8'h12, 8'h34, 8'h56, 8'hFF});
    load_image(ModeRle, 1'b0, pix_cnt_t'(4));
    push_list('{8'hFF, 8'h01, 8'h02, 8'h03});
    load_image(ModeRle, 1'b0, pix_cnt_t'(3));
    push_list('{8'h81, 8'h11, 8'h22, 8'h33, 8'h05, 8'h44, 8'h55, 8'h66});
    load_image(ModeRaw, 1'b0, '0);
    push_list('{8'hAB});
    load_image(ModeUnknown, 1'b1, pix_cnt_t'(5));
    push_list('{8'hCD});
    load_image(ModeRle, 1'b1, '1);
    push_list('{8'hFF, 8'h80, 8'h7F, 8'hFE, 8'h01, 8'h00, 8'h9C, 8'h3D, 8'hE2, 8'h47});

    sent = 0;
    while (sent < RandomBytes) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) mode = ModeNone;
      else if (pick == 1) mode = ModeUnknown;
      else if (pick < 6) mode = ModeRaw;
      else mode = ModeRle;
      alpha = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 15);
      if (pick == 0) total = '0;
      else if (pick == 1) total = '1;
      else if (pick == 2) total = pix_cnt_t'($urandom);
      else if (pick == 3) total = pix_cnt_t'($urandom_range(100, 400));
      else total = pix_cnt_t'($urandom_range(1, 12));
      load_image(mode, alpha, total);
      image_bytes.delete();
      if ((mode != ModeRaw && mode != ModeRle) || total == '0) begin
        repeat ($urandom_range(1, 6)) image_bytes.push_back(8'($urandom_range(0, 255)));
        push_list(image_bytes);
        continue;
      end
      repeat ($urandom_range(1, 3)) build_image(mode, alpha, total);
      if ($urandom_range(0, 7) == 0 && image_bytes.size() > 1) begin
        keep = $urandom_range(1, image_bytes.size() - 1);
        while (image_bytes.size() > keep) void'(image_bytes.pop_back());
      end
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 20)) image_bytes.push_back(8'($urandom_range(0, 255)));
      sent += image_bytes.size();
      push_list(image_bytes);
    end

    wait_quiet();
    if (mismatch_count == 0) begin
      $display("tga_pixel_stream_decoder_core_tb: done, clean");
    end else begin
      $display("tga_pixel_stream_decoder_core_tb: done, errors");
    end
    $finish;
  end

endmodule
